FILE: sv/abrp_pkg.sv
package abrp_pkg;

    // Field and internal widths.
    localparam int MV_W    = 20;
    localparam int PCT_W   = 7;
    localparam int INT_W   = 20;
    localparam int FRAC_W  = 14;
    localparam int FCNT_W  = 3;
    localparam int WIN_W   = 56;
    localparam int TAG_W   = 3;
    localparam int VOLT_W  = 17;
    localparam int DIFF_W  = 11;

    localparam logic [MV_W-1:0]   MV_MAX      = 20'd1048575;
    localparam logic [TAG_W-1:0]  TAG_LEN     = 3'd5;
    localparam logic [FCNT_W-1:0] FRAC_KEEP   = 3'd4;
    localparam logic [INT_W-1:0]  VOLT_LIMIT  = 20'd100;
    localparam logic [MV_W-1:0]   MV_EMPTY    = 20'd3000;
    localparam logic [MV_W-1:0]   MV_FULL     = 20'd4200;
    localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
    localparam logic [FRAC_W-1:0] HALF_MV     = 14'd5000;

    // Reciprocal constants: x*RECIP_10 >> 19 is x/10 for x below 2^16,
    // and x*RECIP_12 >> 15 is x/12 for x below 1200.
    localparam logic [15:0] RECIP_10 = 16'd52429;
    localparam logic [11:0] RECIP_12 = 12'd2731;

    // Terminators, newest byte in the low byte.
    localparam logic [31:0]      TERM_OK    = 32'h4F4B0D0A;
    localparam logic [WIN_W-1:0] TERM_ERROR = 56'h4552524F520D0A;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_UPV   = 8'h56;
    localparam logic [7:0] CH_LOWV  = 8'h76;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK_VOLT = 2'd0,
        ST_OK_NONE = 2'd1,
        ST_ERROR   = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        LP_SEARCH = 3'b001,
        LP_LINE   = 3'b010,
        LP_DONE   = 3'b100
    } line_phase_t;

    typedef enum logic [3:0] {
        FP_LEAD = 4'b0001,
        FP_INT  = 4'b0010,
        FP_FRAC = 4'b0100,
        FP_STOP = 4'b1000
    } field_phase_t;

    // Characters of the battery report tag, in order.
    function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h43;
            3'd2:    ch = 8'h42;
            3'd3:    ch = 8'h43;
            default: ch = 8'h3A;
        endcase
        return ch;
    endfunction

    // Scale that brings the kept fraction digits to four digits.
    function automatic logic [9:0] frac_scale(input logic [FCNT_W-1:0] cnt);
        logic [9:0] s;
        case (cnt)
            3'd2:    s = 10'd100;
            3'd3:    s = 10'd10;
            3'd4:    s = 10'd1;
            default: s = 10'd1000;
        endcase
        return s;
    endfunction

endpackage

FILE: sv/at_battery_response_parser_top.sv
// Battery report reply parser. Items carry either a reply byte (action 0) or a
// reply timeout (action 1); one item is taken every clock cycle while out_stall
// is low, and the next item is taken even while a result waits at the output.
// A result passes, after its item is accepted, through the input register,
// the per-byte parse stage (the update of the tag matcher, the seven-byte
// terminator window and the number parser, which is what fixes the
// one-item-per-cycle rate), a fraction scaling stage, a rounding stage and the
// output register. Exactly one result follows each "OK\r\n", "ERROR\r\n" or
// timeout, after which all parse state is back to its reset value; other items
// give no result. Stages that hold no result close up, so a stalled output
// backs up through the pipeline before in_stall rises.
module at_battery_response_parser_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output abrp_pkg::status_t                 status,
    output logic [abrp_pkg::MV_W-1:0]         millivolts,
    output logic [abrp_pkg::PCT_W-1:0]        percent
);
    import abrp_pkg::*;

    // Pipeline control.
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s0_ready, s1_ready, s2_ready, s3_ready, s4_ready;
    logic s0_go, s0_emits;

    // Input register.
    logic       s0_action_reg;
    logic [7:0] s0_byte_reg;

    // Parse state.
    logic [WIN_W-1:0]  recent_reg, recent_next;
    logic [TAG_W-1:0]  tag_idx_reg, tag_idx_next, tag_try;
    line_phase_t       line_phase_reg, line_phase_next;
    field_phase_t      field_phase_reg, field_phase_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic              seen_reg, seen_next;

    // Byte decode.
    logic       is_digit, is_space, is_vee, ok_hit, err_hit;
    logic [3:0] digit;
    logic [INT_W+3:0]  int_acc;
    logic [FRAC_W+3:0] frac_acc;
    status_t           s0_status;

    // Stage 1: snapshot of the finished reply.
    status_t           s1_status_reg;
    logic              s1_report_reg;
    logic [INT_W-1:0]  s1_int_reg;
    logic [FRAC_W-1:0] s1_frac_reg;
    logic [FCNT_W-1:0] s1_fcnt_reg;

    // Stage 2: four-digit fraction and whole volts in millivolts.
    status_t           s2_status_reg;
    logic              s2_report_reg, s2_small_reg, s2_small_next;
    logic [INT_W-1:0]  s2_int_reg;
    logic [FRAC_W-1:0] s2_f4_reg, s2_f4_next;
    logic [VOLT_W-1:0] s2_volt_reg, s2_volt_next;
    logic [FRAC_W+9:0] f4_prod;

    // Stage 3: rounded millivolts.
    status_t           s3_status_reg;
    logic              s3_report_reg;
    logic [MV_W-1:0]   s3_mv_reg, s3_mv_next;
    logic [FRAC_W+15:0] round_prod;
    logic [FRAC_W-1:0] round_in;
    logic [VOLT_W-1:0] mv_volt;
    logic [MV_W:0]     mv_big;

    // Output register.
    status_t           status_reg, status_next;
    logic [MV_W-1:0]   mv_reg, mv_next;
    logic [PCT_W-1:0]  pct_reg, pct_next;
    logic [DIFF_W-1:0] pct_diff;
    logic [DIFF_W+11:0] pct_prod;

    // Each stage loads when it is empty or its item moves on.
    assign s4_ready = !out_valid_reg || !out_stall;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_go    = s0_valid_reg && (!s0_emits || s1_ready);
    assign s0_ready = !s0_valid_reg || s0_go;
    assign in_stall = !s0_ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_action_reg <= action;
            s0_byte_reg   <= data_byte;
        end
    end

    // Character classes of the current byte.
    always_comb
    begin
        is_digit = (s0_byte_reg >= CH_ZERO) && (s0_byte_reg <= CH_NINE);
        digit    = s0_byte_reg[3:0];
        is_space = (s0_byte_reg == CH_SPACE) || (s0_byte_reg == CH_TAB) ||
                   (s0_byte_reg == CH_VT) || (s0_byte_reg == CH_FF);
        is_vee   = (s0_byte_reg == CH_UPV) || (s0_byte_reg == CH_LOWV);
        int_acc  = {1'b0, int_reg, 3'b000} + {3'b000, int_reg, 1'b0} + {20'd0, digit};
        frac_acc = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0} + {14'd0, digit};
        recent_next = {recent_reg[WIN_W-9:0], s0_byte_reg};
        ok_hit   = (recent_next[31:0] == TERM_OK);
        err_hit  = (recent_next == TERM_ERROR);
        s0_emits = s0_action_reg || ok_hit || err_hit;
        if (s0_action_reg)
        begin
            s0_status = ST_TIMEOUT;
        end
        else if (ok_hit)
        begin
            s0_status = ST_OK_NONE;
        end
        else
        begin
            s0_status = ST_ERROR;
        end
    end

    // Tag matcher, line tracking and number parser for one byte.
    always_comb
    begin
        tag_idx_next     = tag_idx_reg;
        line_phase_next  = line_phase_reg;
        field_phase_next = field_phase_reg;
        int_next         = int_reg;
        frac_next        = frac_reg;
        fcnt_next        = fcnt_reg;
        seen_next        = seen_reg;
        tag_try          = '0;
        case (line_phase_reg)
            LP_SEARCH:
            begin
                if (s0_byte_reg == tag_char(tag_idx_reg))
                begin
                    tag_try = tag_idx_reg + 3'd1;
                end
                else
                begin
                    tag_try = (s0_byte_reg == CH_PLUS) ? 3'd1 : 3'd0;
                end
                if (tag_try == TAG_LEN)
                begin
                    line_phase_next  = LP_LINE;
                    tag_idx_next     = '0;
                    field_phase_next = FP_LEAD;
                    int_next         = '0;
                    frac_next        = '0;
                    fcnt_next        = '0;
                    seen_next        = 1'b0;
                end
                else
                begin
                    tag_idx_next = tag_try;
                end
            end
            LP_LINE:
            begin
                if ((s0_byte_reg == CH_CR) || (s0_byte_reg == CH_LF))
                begin
                    line_phase_next = LP_DONE;
                end
                else if (s0_byte_reg == CH_COMMA)
                begin
                    // A comma opens a new field, so only the last one counts.
                    field_phase_next = FP_LEAD;
                    int_next         = '0;
                    frac_next        = '0;
                    fcnt_next        = '0;
                    seen_next        = 1'b0;
                end
                else if (!is_vee)
                begin
                    case (field_phase_reg)
                        FP_LEAD, FP_INT:
                        begin
                            if (is_digit)
                            begin
                                field_phase_next = FP_INT;
                                seen_next        = 1'b1;
                                if (int_acc > {4'd0, MV_MAX})
                                begin
                                    int_next = MV_MAX;
                                end
                                else
                                begin
                                    int_next = int_acc[INT_W-1:0];
                                end
                            end
                            else if (s0_byte_reg == CH_POINT)
                            begin
                                field_phase_next = FP_FRAC;
                            end
                            else if (!(is_space && (field_phase_reg == FP_LEAD)))
                            begin
                                field_phase_next = FP_STOP;
                            end
                        end
                        FP_FRAC:
                        begin
                            if (is_digit)
                            begin
                                seen_next = 1'b1;
                                // Digits past the fourth are read but not kept.
                                if (fcnt_reg < FRAC_KEEP)
                                begin
                                    frac_next = frac_acc[FRAC_W-1:0];
                                    fcnt_next = fcnt_reg + 3'd1;
                                end
                            end
                            else
                            begin
                                field_phase_next = FP_STOP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // Parse state: a result clears everything back to the reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg      <= '0;
            tag_idx_reg     <= '0;
            line_phase_reg  <= LP_SEARCH;
            field_phase_reg <= FP_LEAD;
            int_reg         <= '0;
            frac_reg        <= '0;
            fcnt_reg        <= '0;
            seen_reg        <= 1'b0;
        end
        else if (s0_go)
        begin
            if (s0_emits)
            begin
                recent_reg      <= '0;
                tag_idx_reg     <= '0;
                line_phase_reg  <= LP_SEARCH;
                field_phase_reg <= FP_LEAD;
                int_reg         <= '0;
                frac_reg        <= '0;
                fcnt_reg        <= '0;
                seen_reg        <= 1'b0;
            end
            else
            begin
                recent_reg      <= recent_next;
                tag_idx_reg     <= tag_idx_next;
                line_phase_reg  <= line_phase_next;
                field_phase_reg <= field_phase_next;
                int_reg         <= int_next;
                frac_reg        <= frac_next;
                fcnt_reg        <= fcnt_next;
                seen_reg        <= seen_next;
            end
        end
    end

    // Stage 2 and 3 arithmetic.
    always_comb
    begin
        f4_prod       = {10'd0, s1_frac_reg} * {14'd0, frac_scale(s1_fcnt_reg)};
        s2_f4_next    = f4_prod[FRAC_W-1:0];
        s2_volt_next  = {10'd0, s1_int_reg[6:0]} * 17'd1000;
        s2_small_next = (s1_int_reg < VOLT_LIMIT);

        // Round half up to whole millivolts.
        round_in   = s2_f4_reg + 14'd5;
        round_prod = {16'd0, round_in} * {14'd0, RECIP_10};
        mv_volt    = s2_volt_reg + {6'd0, round_prod[FRAC_W+15:19]};
        mv_big     = {1'b0, s2_int_reg} + {20'd0, (s2_f4_reg >= HALF_MV)};
        if (s2_small_reg)
        begin
            s3_mv_next = {3'd0, mv_volt};
        end
        else if (mv_big[MV_W])
        begin
            s3_mv_next = MV_MAX;
        end
        else
        begin
            s3_mv_next = mv_big[MV_W-1:0];
        end
    end

    // Final status and linear charge estimate.
    always_comb
    begin
        pct_diff    = s3_mv_reg[DIFF_W-1:0] - MV_EMPTY[DIFF_W-1:0];
        pct_prod    = {12'd0, pct_diff} * {11'd0, RECIP_12};
        status_next = s3_status_reg;
        mv_next     = '0;
        pct_next    = '0;
        if ((s3_status_reg == ST_OK_NONE) && s3_report_reg && (s3_mv_reg != '0))
        begin
            status_next = ST_OK_VOLT;
            mv_next     = s3_mv_reg;
            if (s3_mv_reg >= MV_FULL)
            begin
                pct_next = PCT_FULL;
            end
            else if (s3_mv_reg > MV_EMPTY)
            begin
                pct_next = pct_prod[PCT_W+14:15];
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s0_go && s0_emits;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (s1_ready && s0_go && s0_emits)
        begin
            s1_status_reg <= s0_status;
            s1_report_reg <= (line_phase_next != LP_SEARCH) && seen_next;
            s1_int_reg    <= int_next;
            s1_frac_reg   <= frac_next;
            s1_fcnt_reg   <= fcnt_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_report_reg <= s1_report_reg;
            s2_int_reg    <= s1_int_reg;
            s2_f4_reg     <= s2_f4_next;
            s2_volt_reg   <= s2_volt_next;
            s2_small_reg  <= s2_small_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_status_reg <= s2_status_reg;
            s3_report_reg <= s2_report_reg;
            s3_mv_reg     <= s3_mv_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            status_reg <= status_next;
            mv_reg     <= mv_next;
            pct_reg    <= pct_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign millivolts = mv_reg;
    assign percent    = pct_reg;

`ifndef ASSERT_OFF
    // Only a voltage report carries a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK_VOLT) |-> (millivolts == '0) && (percent == '0))
    else $error("value fields set without a voltage report");

    // A voltage report is never zero and the estimate stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK_VOLT) |-> (millivolts != '0) && (percent <= PCT_FULL))
    else $error("voltage report out of range");

    // A finished reply leaves the parser in its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        s0_go && s0_emits |=> (recent_reg == '0) && (tag_idx_reg == '0) &&
            (line_phase_reg == LP_SEARCH) && (seen_reg == 1'b0))
    else $error("parse state not cleared after a result");

    // The tag matcher never reaches the full tag length while searching.
    assert property (@(posedge clk) disable iff (!rst_n)
        tag_idx_reg < TAG_LEN)
    else $error("tag match index out of range");

    // Kept fraction digits stay within four digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fcnt_reg <= FRAC_KEEP) && (frac_reg < 14'd10000))
    else $error("fraction digits overflow");
`endif

endmodule

FILE: sim/tb_top.sv
module tb_top;
    import abrp_pkg::*;

    localparam int QUIET_LIMIT = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 800;
    localparam logic [39:0] CBC_TAG = "+CBC:";

    // One parsed battery reading as it leaves the block.
    typedef struct {
        status_t              st;
        logic [MV_W-1:0]      mv;
        logic [PCT_W-1:0]     pct;
    } reading_t;

    // Reply parser model plus the queue of readings still to come out.
    class cbc_checker;
        logic [WIN_W-1:0] window;
        int unsigned      tag_idx;
        line_phase_t      line_ph;
        field_phase_t     fld_ph;
        int unsigned      int_part;
        int unsigned      frac;
        int unsigned      fcnt;
        bit               seen;
        reading_t         expected_q[$];
        int               mismatches;

        function new();
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_field();
            fld_ph = FP_LEAD;
            int_part = 0;
            frac = 0;
            fcnt = 0;
            seen = 1'b0;
        endfunction

        function void clear_parse();
            window = '0;
            tag_idx = 0;
            line_ph = LP_SEARCH;
            clear_field();
        endfunction

        // Number parsing of one character inside the report field.
        function void field_char(logic [7:0] c);
            bit          is_dig;
            int unsigned d;
            int unsigned ceiling;
            is_dig = (c >= CH_ZERO && c <= CH_NINE);
            d = c - CH_ZERO;
            ceiling = MV_MAX;
            if (c == CH_UPV || c == CH_LOWV || fld_ph == FP_STOP)
                return;
            if (fld_ph == FP_LEAD &&
                (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF))
                return;
            if (fld_ph == FP_LEAD || fld_ph == FP_INT)
            begin
                if (is_dig)
                begin
                    fld_ph = FP_INT;
                    seen = 1'b1;
                    if (int_part > (ceiling - d) / 10)
                        int_part = ceiling;
                    else
                        int_part = int_part * 10 + d;
                end
                else if (c == CH_POINT)
                    fld_ph = FP_FRAC;
                else
                    fld_ph = FP_STOP;
                return;
            end
            if (is_dig)
            begin
                seen = 1'b1;
                if (fcnt < 4)
                begin
                    frac = frac * 10 + d;
                    fcnt++;
                end
            end
            else
                fld_ph = FP_STOP;
        endfunction

        // Tag search and line tracking for one received character.
        function void line_char(logic [7:0] c);
            int unsigned i;
            if (line_ph == LP_SEARCH)
            begin
                i = tag_idx;
                if (i < 5 && c == CBC_TAG[39 - 8 * i -: 8])
                    i++;
                else
                    i = (c == CH_PLUS) ? 1 : 0;
                if (i >= 5)
                begin
                    line_ph = LP_LINE;
                    tag_idx = 0;
                    clear_field();
                end
                else
                    tag_idx = i;
            end
            else if (line_ph == LP_LINE)
            begin
                if (c == CH_CR || c == CH_LF)
                    line_ph = LP_DONE;
                else if (c == CH_COMMA)
                    clear_field();
                else
                    field_char(c);
            end
        endfunction

        // Field value rounded to millivolts.
        function int unsigned field_mv();
            int unsigned f4;
            int unsigned first;
            int unsigned mv;
            if (int_part < 100)
            begin
                f4 = frac;
                for (int k = fcnt; k < 4; k++)
                    f4 *= 10;
                mv = int_part * 1000 + (f4 + 5) / 10;
            end
            else
            begin
                first = 0;
                if (fcnt > 0)
                begin
                    first = frac;
                    for (int k = 1; k < fcnt; k++)
                        first /= 10;
                end
                mv = int_part + ((first >= 5) ? 1 : 0);
                if (mv > MV_MAX)
                    mv = MV_MAX;
            end
            return mv;
        endfunction

        // Record an accepted item and queue the reading it ends, if any.
        function void note_item(bit act, logic [7:0] c);
            reading_t    r;
            bit          fire;
            int unsigned v;
            fire = 1'b0;
            r.st = ST_TIMEOUT;
            r.mv = '0;
            r.pct = '0;
            if (act)
                fire = 1'b1;
            else
            begin
                line_char(c);
                window = {window[WIN_W-9:0], c};
                if (window[31:0] == TERM_OK)
                begin
                    fire = 1'b1;
                    r.st = ST_OK_NONE;
                    if (line_ph != LP_SEARCH && seen)
                    begin
                        v = field_mv();
                        if (v > 0)
                        begin
                            r.st = ST_OK_VOLT;
                            r.mv = v[MV_W-1:0];
                            if (v >= 4200)
                                r.pct = PCT_FULL;
                            else if (v > 3000)
                                r.pct = PCT_W'((v - 3000) * 100 / 1200);
                        end
                    end
                end
                else if (window == TERM_ERROR)
                begin
                    fire = 1'b1;
                    r.st = ST_ERROR;
                end
            end
            if (fire)
            begin
                expected_q.push_back(r);
                clear_parse();
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        // Compare a reading from the block with the oldest expected one.
        function void check_reading(status_t st, logic [MV_W-1:0] mv,
                                    logic [PCT_W-1:0] pct);
            reading_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected reading: status %0d mv %0d pct %0d",
                                 st, mv, pct));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.st || mv !== want.mv || pct !== want.pct)
                report($sformatf({"reading mismatch: expected status %0d mv %0d pct %0d,",
                                  " got status %0d mv %0d pct %0d"},
                                 want.st, want.mv, want.pct, st, mv, pct));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action = 1'b0;
    logic [7:0]         data_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    status_t            status;
    logic [MV_W-1:0]    millivolts;
    logic [PCT_W-1:0]   percent;

    cbc_checker         sb = new();
    logic [8:0]         item_q[$];
    bit                 send_idle = 1'b0;
    bit                 take_idle = 1'b0;
    int                 quiet_cycles = 0;
    int                 sent_items = 0;

    at_battery_response_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .millivolts (millivolts),
        .percent    (percent)
    );

    always #5 clk = ~clk;

    // Watch both channels: note accepted items and check accepted readings.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(action, data_byte);
        if (rst_n && out_valid && !out_stall)
            sb.check_reading(status, millivolts, percent);
    end

    // End the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int draw_gap(bit idle);
        return idle ? $urandom_range(0, 9) : 0;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        item_q.push_back({1'b0, b});
    endfunction

    function automatic void add_timeout();
        item_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endfunction

    function automatic void add_ok();
        add_text("OK");
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void add_error();
        add_text("ERROR");
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    // Digits; a battery-like first digit is 3 or 4.
    function automatic void add_digits(int n, bit battery_like);
        for (int k = 0; k < n; k++)
            if (k == 0 && battery_like)
                add_byte(CH_ZERO + 8'($urandom_range(3, 4)));
            else
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_junk();
        case ($urandom_range(0, 5))
            0:       return "-";
            1:       return CH_PLUS;
            2:       return "e";
            3:       return "E";
            4:       return CH_POINT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 3))
            0, 1:
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            2:       add_byte(CH_LF);
            default: add_byte(CH_CR);
        endcase
    endfunction

    // One comma field: blanks, a number in volts or millivolts, unit and junk.
    function automatic void add_field();
        repeat ($urandom_range(0, 3)) add_byte(pick_blank());
        if ($urandom_range(0, 5) == 0)
            add_byte(CH_LOWV);
        case ($urandom_range(0, 5))
            0, 1:
            begin
                add_digits(1, $urandom_range(0, 3) != 0);
                add_byte(CH_POINT);
                add_digits($urandom_range(0, 6), 1'b0);
            end
            2:
            begin
                add_digits(4, 1'b1);
                if ($urandom_range(0, 1) == 1)
                begin
                    add_byte(CH_POINT);
                    add_digits($urandom_range(0, 2), 1'b0);
                end
            end
            3:
            begin
                add_digits($urandom_range(0, 8), 1'b0);
                if ($urandom_range(0, 1) == 1)
                begin
                    add_byte(CH_POINT);
                    add_digits($urandom_range(0, 3), 1'b0);
                end
            end
            4:
            begin
                add_byte(CH_POINT);
                add_digits($urandom_range(1, 5), 1'b0);
            end
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
            add_byte($urandom_range(0, 1) ? CH_UPV : CH_LOWV);
        if ($urandom_range(0, 4) == 0)
        begin
            add_byte(pick_junk());
            add_digits($urandom_range(0, 2), 1'b0);
        end
    endfunction

    // A whole reply: mostly well-formed battery reports, some noise or cut short.
    function automatic void build_reply();
        int kind;
        int ending;
        int fields;
        kind = $urandom_range(0, 9);
        ending = $urandom_range(0, 9);
        if (kind < 8)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_text("AT+CBC");
                add_byte(CH_CR);
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            add_text("+CBC:");
            fields = $urandom_range(1, 3);
            for (int k = 0; k < fields; k++)
            begin
                if (k > 0)
                    add_byte(CH_COMMA);
                add_field();
            end
            // Leaving out the line end puts the terminator inside the tag line.
            if ($urandom_range(0, 7) != 0)
            begin
                add_line_end();
                if ($urandom_range(0, 5) == 0)
                begin
                    add_text("+CBC: ");
                    add_field();
                    add_line_end();
                end
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        end
        else if (kind == 8)
            repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
        else
        begin
            add_text("+CB");
            if ($urandom_range(0, 1) == 1)
            begin
                add_text("C:");
                add_field();
            end
            case ($urandom_range(0, 3))
                0:       add_text("O");
                1:
                begin
                    add_text("OK");
                    add_byte(CH_CR);
                end
                2:       add_text("ERRO");
                default:
                begin
                    add_text("ERROR");
                    add_byte(CH_CR);
                end
            endcase
            ending = 9;
        end
        if (ending < 7)
            add_ok();
        else if (ending < 9)
            add_error();
        else
            add_timeout();
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(bit act, logic [7:0] b);
        int gap;
        gap = draw_gap(send_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic play_items();
        logic [8:0] it;
        while (item_q.size() > 0)
        begin
            it = item_q.pop_front();
            send_item(it[8], it[7:0]);
        end
    endtask

    // Result side: stall for a drawn number of cycles before each reading.
    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap(take_idle);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Timeout with a stray byte, an error reply, a terminator inside the
        // tag line, and a bare OK with no report.
        item_q.push_back({1'b1, 8'hFF});
        add_error();
        add_text("+CBC: 4.2V");
        add_ok();
        add_ok();
        play_items();

        // Random replies with idling switched on and off per reply.
        while (sent_items < RANDOM_ITEMS)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            take_idle = ($urandom_range(0, 3) != 0);
            build_reply();
            sent_items += item_q.size();
            play_items();
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
